@@ rtl/dkia_pkg.sv @@
`default_nettype none

package dkia_pkg;

    localparam int ACT_W   = 2;
    localparam int KEY_W   = 32;
    localparam int IDENT_W = 4 * KEY_W;
    localparam int IN_W    = IDENT_W + KEY_W;
    localparam int IDX_W   = 8;
    localparam int OUSER_W = 2;

    localparam logic [ACT_W-1:0] ACT_IDENT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEVICE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HOSTID = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/dkia_ram.sv @@
`default_nettype none

module dkia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dkia_ctrl.sv @@
`default_nettype none

module dkia_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dkia_pkg::t_status i_status,
    output dkia_pkg::t_cmd       o_cmd
);

    dkia_pkg::t_state r_state;
    dkia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dkia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dkia_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = dkia_pkg::S_SEARCH;
                end
            end
            dkia_pkg::S_SEARCH: begin
                if (i_status.hit || i_status.exhausted) begin
                    n_state = dkia_pkg::S_FINISH;
                end
            end
            dkia_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = dkia_pkg::S_IDLE;
                end
            end
            default: n_state = dkia_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            dkia_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dkia_pkg::S_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            dkia_pkg::S_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/dkia_datapath.sv @@
`default_nettype none

module dkia_datapath #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    input  wire logic [dkia_pkg::ACT_W-1:0]    i_in_action,
    input  wire logic [dkia_pkg::IN_W-1:0]     i_in_data,
    input  wire dkia_pkg::t_cmd                i_cmd,
    output dkia_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [dkia_pkg::IDX_W-1:0]    o_out_index,
    output logic      [dkia_pkg::OUSER_W-1:0]  o_out_flags
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    logic                           r_collapse;
    logic [dkia_pkg::ACT_W-1:0]     r_action;
    logic [dkia_pkg::IDENT_W-1:0]   r_ident;
    logic [dkia_pkg::KEY_W-1:0]     r_word;
    logic [CW-1:0]                  r_ident_cnt;
    logic [CW-1:0]                  r_dev_cnt;
    logic [CW-1:0]                  r_host_cnt;
    logic [CW-1:0]                  r_rd_cnt;
    logic                           r_cmp_vld;
    logic [AW-1:0]                  r_cmp_addr;
    logic                           r_hit;
    logic [AW-1:0]                  r_hit_idx;
    logic                           r_out_new;
    logic                           r_out_full;

    logic [CW-1:0]                  sel_cnt;
    logic                           bypass;
    logic                           issue;
    logic                           match;
    logic                           full;
    logic                           insert;
    logic [dkia_pkg::IDENT_W-1:0]   rd_ident;
    logic [dkia_pkg::KEY_W-1:0]     rd_dev;
    logic [dkia_pkg::KEY_W-1:0]     rd_host;
    logic [CW+dkia_pkg::IDX_W-1:0]  cnt_ext;
    logic [AW+dkia_pkg::IDX_W-1:0]  hit_ext;
    logic [dkia_pkg::IDX_W-1:0]     n_index;

    always_comb begin
        unique case (r_action)
            dkia_pkg::ACT_IDENT:  sel_cnt = r_ident_cnt;
            dkia_pkg::ACT_DEVICE: sel_cnt = r_dev_cnt;
            dkia_pkg::ACT_HOSTID: sel_cnt = r_host_cnt;
            default:              sel_cnt = '0;
        endcase
    end

    always_comb begin
        unique case (r_action)
            dkia_pkg::ACT_IDENT:  match = (rd_ident == r_ident);
            dkia_pkg::ACT_DEVICE: match = (rd_dev == r_word);
            dkia_pkg::ACT_HOSTID: match = (rd_host == r_word);
            default:              match = 1'b0;
        endcase
    end

    assign bypass = r_collapse || (r_action == dkia_pkg::ACT_UNUSED);
    assign issue  = i_cmd.search && !bypass && (r_rd_cnt != sel_cnt) && !o_status.hit;
    assign full   = (sel_cnt == FULL_CNT);
    assign insert = !bypass && !r_hit && !full;

    assign o_status.hit       = r_cmp_vld && match;
    assign o_status.exhausted = bypass || ((r_rd_cnt == sel_cnt) && !r_cmp_vld);
    assign o_status.out_free  = !o_out_valid || i_out_ready;

    assign cnt_ext = {{dkia_pkg::IDX_W{1'b0}}, sel_cnt};
    assign hit_ext = {{dkia_pkg::IDX_W{1'b0}}, r_hit_idx};

    always_comb begin
        priority if (bypass) begin
            n_index = '0;
        end else if (r_hit) begin
            n_index = hit_ext[dkia_pkg::IDX_W-1:0];
        end else if (full) begin
            n_index = '0;
        end else begin
            n_index = cnt_ext[dkia_pkg::IDX_W-1:0];
        end
    end

    dkia_ram #(.WIDTH(dkia_pkg::IDENT_W), .DEPTH(TABLE_ENTRIES)) u_ident_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && insert && (r_action == dkia_pkg::ACT_IDENT)),
        .i_waddr (sel_cnt[AW-1:0]),
        .i_wdata (r_ident),
        .i_re    (issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rd_ident)
    );

    dkia_ram #(.WIDTH(dkia_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_dev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && insert && (r_action == dkia_pkg::ACT_DEVICE)),
        .i_waddr (sel_cnt[AW-1:0]),
        .i_wdata (r_word),
        .i_re    (issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rd_dev)
    );

    dkia_ram #(.WIDTH(dkia_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_host_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && insert && (r_action == dkia_pkg::ACT_HOSTID)),
        .i_waddr (sel_cnt[AW-1:0]),
        .i_wdata (r_word),
        .i_re    (issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rd_host)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collapse  <= 1'b0;
            r_ident_cnt <= '0;
            r_dev_cnt   <= '0;
            r_host_cnt  <= '0;
            r_rd_cnt    <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_collapse <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_rd_cnt  <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end
            if (i_cmd.search) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_cnt <= r_rd_cnt + CW'(1);
                end
                if (o_status.hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.finish && insert) begin
                unique case (r_action)
                    dkia_pkg::ACT_IDENT:  r_ident_cnt <= r_ident_cnt + CW'(1);
                    dkia_pkg::ACT_DEVICE: r_dev_cnt   <= r_dev_cnt + CW'(1);
                    dkia_pkg::ACT_HOSTID: r_host_cnt  <= r_host_cnt + CW'(1);
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_action;
            r_ident  <= {i_in_data[31:0], i_in_data[63:32], i_in_data[95:64],
                         i_in_data[127:96]};
            r_word   <= i_in_data[159:128];
        end
        if (i_cmd.search) begin
            r_cmp_addr <= r_rd_cnt[AW-1:0];
            if (o_status.hit) begin
                r_hit_idx <= r_cmp_addr;
            end
        end
        if (i_cmd.finish) begin
            o_out_index <= n_index;
            r_out_new   <= insert;
            r_out_full  <= !bypass && !r_hit && full;
        end
    end

    assign o_out_flags = {r_out_full, r_out_new};

endmodule

`default_nettype wire

@@ rtl/dense_key_index_assigner.sv @@
`default_nettype none

// Channel | Direction | Fields
// s_axis  | in        | tdata: id_host, id_channel, id_target, id_lun, word_key; tuser: action
// m_axis  | out       | tdata: index; tuser: was_new, table_full
// cfg     | in        | i_cfg_we, i_cfg_wdata: collapse_all
//
// A search reads up to n entries, where n is the number of entries stored in the named
// table, at most TABLE_ENTRIES, and stops at a hit. The single read port of the key
// memories walks the stored entries one a cycle. Collapse-all and unused requests skip
// the walk. Reset clears the counts and the mode register; key memories are not
// cleared. A finished result waits in the output register; the next request is accepted
// meanwhile, and a stalled output holds the controller before its next result.

module dense_key_index_assigner #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // id_host, id_channel, id_target, id_lun, word_key from bit 0 up.
    input  wire logic [159:0]  s_axis_tdata,
    // action.
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // index.
    output logic      [7:0]    m_axis_tdata,
    // was_new, table_full from bit 0 up.
    output logic      [1:0]    m_axis_tuser
);

    dkia_pkg::t_cmd    w_cmd;
    dkia_pkg::t_status w_status;

    dkia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dkia_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_action (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_index (m_axis_tdata),
        .o_out_flags (m_axis_tuser)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.search, w_cmd.finish}))
        else $error("more than one command at once");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    a_hit_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.hit |-> !w_status.exhausted)
        else $error("hit and exhausted together");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finish");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("new and full flagged together");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_ENTRIES = 256;
    localparam int HOLD_CYCLES   = 1500;
    localparam int STALL_LIMIT   = 20000;

    typedef struct {
        logic [dkia_pkg::ACT_W-1:0] action;
        logic [31:0]                id_host;
        logic [31:0]                id_channel;
        logic [31:0]                id_target;
        logic [31:0]                id_lun;
        logic [31:0]                word_key;
    } t_key_request;

    typedef struct {
        logic [dkia_pkg::IDX_W-1:0] index;
        logic                       was_new;
        logic                       table_full;
    } t_index_result;

    typedef struct packed {
        logic [dkia_pkg::ACT_W-1:0] action;
        logic [31:0]                id_host;
        logic [31:0]                id_channel;
        logic [31:0]                id_target;
        logic [31:0]                id_lun;
        logic [31:0]                word_key;
        logic                       typed;
        logic [dkia_pkg::IDX_W-1:0] index;
        logic                       was_new;
        logic                       table_full;
    } t_directed_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // id_host, id_channel, id_target, id_lun, word_key from bit 0 up.
    logic [159:0]       s_axis_tdata = '0;
    // action.
    logic [1:0]         s_axis_tuser = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // index.
    logic [7:0]         m_axis_tdata;
    // was_new, table_full from bit 0 up.
    logic [1:0]         m_axis_tuser;

    logic [127:0]       key_store [3][TABLE_ENTRIES];
    int                 key_used [3];
    logic               collapse_mode = 1'b0;
    t_index_result      pending_indices [$];
    logic [127:0]       ident_seen [$];
    logic [31:0]        device_seen [$];
    logic [31:0]        hostid_seen [$];
    t_directed_row      directed_rows [18];
    t_index_result      no_result;

    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    bit                 hold_request = 1'b0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    dense_key_index_assigner #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Collapse-all mode and the unused action leave the tables alone; a full table
    // still finds the keys it holds.
    function automatic t_index_result lookup_dense_index(input t_key_request r);
        t_index_result res;
        logic [127:0]  key;
        int            tbl;
        int            pos;
        res.index = '0;
        res.was_new = 1'b0;
        res.table_full = 1'b0;
        if (collapse_mode || r.action == dkia_pkg::ACT_UNUSED) begin
            return res;
        end
        tbl = int'(r.action);
        pos = -1;
        if (r.action == dkia_pkg::ACT_IDENT) begin
            key = {r.id_host, r.id_channel, r.id_target, r.id_lun};
        end else begin
            key = {96'd0, r.word_key};
        end
        for (int k = 0; k < key_used[tbl]; k++) begin
            if (pos < 0 && key_store[tbl][k] == key) begin
                pos = k;
            end
        end
        if (pos >= 0) begin
            res.index = 8'(pos);
        end else if (key_used[tbl] >= TABLE_ENTRIES) begin
            res.table_full = 1'b1;
        end else begin
            key_store[tbl][key_used[tbl]] = key;
            res.index = 8'(key_used[tbl]);
            res.was_new = 1'b1;
            key_used[tbl]++;
        end
        return res;
    endfunction

    // Mostly fresh keys so that every table fills up, with repeats and near misses
    // that differ from an earlier key in a single bit.
    function automatic t_key_request draw_request();
        t_key_request r;
        logic [127:0] ident;
        int           roll;
        r.id_host = $urandom;
        r.id_channel = $urandom;
        r.id_target = $urandom;
        r.id_lun = $urandom;
        r.word_key = $urandom;
        roll = $urandom_range(99);
        if (roll < 5) begin
            r.action = dkia_pkg::ACT_UNUSED;
        end else if (roll < 37) begin
            r.action = dkia_pkg::ACT_IDENT;
        end else if (roll < 69) begin
            r.action = dkia_pkg::ACT_DEVICE;
        end else begin
            r.action = dkia_pkg::ACT_HOSTID;
        end
        roll = $urandom_range(99);
        if (r.action == dkia_pkg::ACT_IDENT) begin
            ident = {r.id_host, r.id_channel, r.id_target, r.id_lun};
            if (roll < 25 && ident_seen.size() != 0) begin
                ident = ident_seen[$urandom_range(ident_seen.size() - 1)];
                if (roll < 8) begin
                    ident ^= 128'd1 << $urandom_range(127);
                end
            end
            ident_seen.push_back(ident);
            {r.id_host, r.id_channel, r.id_target, r.id_lun} = ident;
        end else if (r.action == dkia_pkg::ACT_DEVICE) begin
            if (roll < 25 && device_seen.size() != 0) begin
                r.word_key = device_seen[$urandom_range(device_seen.size() - 1)];
                if (roll < 8) begin
                    r.word_key ^= 32'd1 << $urandom_range(31);
                end
            end
            device_seen.push_back(r.word_key);
        end else if (r.action == dkia_pkg::ACT_HOSTID) begin
            if (roll < 25 && hostid_seen.size() != 0) begin
                r.word_key = hostid_seen[$urandom_range(hostid_seen.size() - 1)];
                if (roll < 8) begin
                    r.word_key ^= 32'd1 << $urandom_range(31);
                end
            end
            hostid_seen.push_back(r.word_key);
        end
        return r;
    endfunction

    task automatic send_request(input t_key_request r, input bit typed,
                                input t_index_result typed_result);
        t_index_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.action;
        s_axis_tdata <= {r.word_key, r.id_lun, r.id_target, r.id_channel, r.id_host};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predicted = lookup_dense_index(r);
        pending_indices.push_back(typed ? typed_result : predicted);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(draw_request(), 1'b0, no_result);
        end
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_indices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_collapse(input logic value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        collapse_mode = value;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_index_result got;
        t_index_result want;
        bit            moved;
        if (i_rst_n) begin
            moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
            if (m_axis_tvalid && m_axis_tready) begin
                got.index = m_axis_tdata;
                got.was_new = m_axis_tuser[0];
                got.table_full = m_axis_tuser[1];
                if (pending_indices.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unrequested result: index %0d was_new %0b table_full %0b",
                                 got.index, got.was_new, got.table_full);
                    end
                end else begin
                    want = pending_indices.pop_front();
                    if (got.index !== want.index || got.was_new !== want.was_new
                        || got.table_full !== want.table_full) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"index %0d/%0d was_new %0b/%0b ",
                                      "table_full %0b/%0b (exp/got)"},
                                     want.index, got.index, want.was_new, got.was_new,
                                     want.table_full, got.table_full);
                        end
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_key_request  r;
        t_index_result typed_result;
        no_result.index = '0;
        no_result.was_new = 1'b0;
        no_result.table_full = 1'b0;
        key_used = '{0, 0, 0};
        directed_rows = '{
            '{dkia_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
              1'b1, 8'd0, 1'b1, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0, 1'b1, 8'd1, 1'b1, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0, 32'h0, 32'h5A5A_5A5A,
              1'b1, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_DEVICE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd0, 1'b1, 1'b0},
            '{dkia_pkg::ACT_DEVICE, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
              1'b1, 8'd1, 1'b1, 1'b0},
            '{dkia_pkg::ACT_HOSTID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b1, 1'b0},
            '{dkia_pkg::ACT_HOSTID, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd1, 1'b1, 1'b0},
            '{dkia_pkg::ACT_DEVICE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_UNUSED, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd2, 1'b1, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
              1'b1, 8'd3, 1'b1, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
              1'b1, 8'd4, 1'b1, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
              1'b1, 8'd5, 1'b1, 1'b0},
            '{dkia_pkg::ACT_HOSTID, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
              1'b1, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 8'd1, 1'b0, 1'b0},
            '{dkia_pkg::ACT_DEVICE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0001,
              1'b0, 8'd0, 1'b0, 1'b0},
            '{dkia_pkg::ACT_IDENT, 32'h1, 32'h2, 32'h3, 32'h4, 32'h0,
              1'b0, 8'd0, 1'b0, 1'b0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_collapse(1'b0);

        tx_idle_pct = 28;
        rx_idle_pct = 71;
        foreach (directed_rows[n]) begin
            r.action = directed_rows[n].action;
            r.id_host = directed_rows[n].id_host;
            r.id_channel = directed_rows[n].id_channel;
            r.id_target = directed_rows[n].id_target;
            r.id_lun = directed_rows[n].id_lun;
            r.word_key = directed_rows[n].word_key;
            typed_result.index = directed_rows[n].index;
            typed_result.was_new = directed_rows[n].was_new;
            typed_result.table_full = directed_rows[n].table_full;
            send_request(r, directed_rows[n].typed, typed_result);
        end
        hold_request = 1'b1;
        send_random(400);

        settle_block();
        write_collapse(1'b1);
        tx_idle_pct = 71;
        rx_idle_pct = 28;
        send_random(120);

        settle_block();
        write_collapse(1'b0);
        send_random(430);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(430);

        settle_block();
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ dense_key_index_assigner.f @@
rtl/dkia_pkg.sv
rtl/dkia_ram.sv
rtl/dkia_ctrl.sv
rtl/dkia_datapath.sv
rtl/dense_key_index_assigner.sv
test/testbench.sv
